### hw/rtl/sacr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacr_pkg
// Types, constants and helpers shared by the cache replacement engine.
// ----------------------------------------------------------------------------
package sacr_pkg;

    localparam int NUM_SETS   = 256;
    localparam int WAYS       = 4;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_BITS  = 32;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(WAYS);
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int TAG_W = ADDR_BITS - OFF_W;
    localparam int ID_W  = 10;

    typedef logic [1:0] t_action;
    localparam t_action ACT_LOOKUP  = 2'd0;
    localparam t_action ACT_REPLACE = 2'd1;
    localparam t_action ACT_FLAGS   = 2'd2;

    typedef logic [WAYS-1:0][WAY_W-1:0] t_order;

    // one set: per-way tag and flags, plus recency order (slot 0 newest)
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tag;
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0]            locked;
        t_order                     order;
    } t_row;

    typedef struct packed {
        logic             hit;
        logic             found;
        logic [ID_W-1:0]  line_id;
        logic             victim_valid;
        logic [26:0]      victim_line_address;
    } t_result;

    function automatic t_row reset_row();
        t_row r;
        r = '0;
        for (int k = 0; k < WAYS; k++) begin
            r.order[k] = WAY_W'(k);
        end
        return r;
    endfunction

    // move the way in slot to slot 0, shifting younger ones down
    function automatic t_order to_front(input t_order o, input logic [WAY_W-1:0] slot);
        t_order n;
        n = o;
        for (int s = 1; s < WAYS; s++) begin
            if (WAY_W'(s) <= slot) begin
                n[s] = o[s-1];
            end
        end
        n[0] = o[slot];
        return n;
    endfunction

endpackage

### hw/rtl/set_assoc_cache_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_replacement_core
// Tag and LRU replacement engine of a set-associative cache.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   The item's set row is read from the set memory at that edge; the next
//   cycle compares all ways of the row in parallel, picks hit or victim,
//   writes the row back and shows the result for one cycle with o_valid.
//   Busy stays high in the result cycle, so a new item is not taken until
//   the row write-back at the end of that cycle is done and the next row
//   read sees the updated row.
//   Results cannot be held off by the receiver; they must be taken when
//   o_valid is high.
//   Config: i_cfg_we writes nxlru_mode from i_cfg_wdata; write only idle.
//   Reset: per-set valid flags clear at once, so every set reads as empty
//   with identity recency order; no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_cache_replacement_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_address,
    input  logic        i_ignore_locked,
    input  logic        i_new_valid,
    input  logic        i_new_locked,
    output logic        o_valid,
    output logic        o_hit,
    output logic        o_found,
    output logic [9:0]  o_line_id,
    output logic        o_victim_valid,
    output logic [26:0] o_victim_line_address
);
    import sacr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic                 r_mode;
    logic [NUM_SETS-1:0]  r_row_ok;
    logic                 r_ok_q;
    logic [TAG_W-1:0]     r_tag;
    t_action              r_action;
    logic                 r_ign, r_nv, r_nl;

    logic                 accept;
    logic [TAG_W-1:0]     in_tag;
    t_row                 rdata, row, wrow;
    t_result              res;
    logic                 we;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign in_tag = i_address[ADDR_BITS-1:OFF_W];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mode   <= 1'b0;
            r_row_ok <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_state == ST_EXEC && we) begin
                r_row_ok[r_tag[SET_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag    <= in_tag;
            r_action <= i_action;
            r_ign    <= i_ignore_locked;
            r_nv     <= i_new_valid;
            r_nl     <= i_new_locked;
            r_ok_q   <= r_row_ok[in_tag[SET_W-1:0]];
        end
    end

    sacr_set_ram u_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_EXEC) && we),
        .i_waddr (r_tag[SET_W-1:0]),
        .i_wdata (wrow),
        .i_re    (accept),
        .i_raddr (in_tag[SET_W-1:0]),
        .o_rdata (rdata)
    );

    // untouched set reads as its reset contents
    assign row = r_ok_q ? rdata : reset_row();

    sacr_pick u_pick (
        .i_row           (row),
        .i_tag           (r_tag),
        .i_action        (r_action),
        .i_ignore_locked (r_ign),
        .i_new_valid     (r_nv),
        .i_new_locked    (r_nl),
        .i_mode          (r_mode),
        .o_res           (res),
        .o_row           (wrow),
        .o_we            (we)
    );

    assign o_valid               = (r_state == ST_EXEC);
    assign o_hit                 = res.hit;
    assign o_found               = res.found;
    assign o_line_id             = res.line_id;
    assign o_victim_valid        = res.victim_valid;
    assign o_victim_line_address = res.victim_line_address;

    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept)) else $error("result without accepted item");
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_found && !o_victim_valid))
        else $error("hit with victim or not found");
    a_no_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_line_id == '0 && !o_victim_valid))
        else $error("fields set without a line");
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("two results for one item");

endmodule

### hw/rtl/sacr_set_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacr_set_ram
// One row per set: tags, flags and recency order. Registered read.
// ----------------------------------------------------------------------------
module sacr_set_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [sacr_pkg::SET_W-1:0] i_waddr,
    input  sacr_pkg::t_row            i_wdata,
    input  logic                      i_re,
    input  logic [sacr_pkg::SET_W-1:0] i_raddr,
    output sacr_pkg::t_row            o_rdata
);
    import sacr_pkg::*;

    t_row r_mem [NUM_SETS];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sacr_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacr_pick
// Hit search, victim choice and row update for one set.
// ----------------------------------------------------------------------------
module sacr_pick (
    input  sacr_pkg::t_row             i_row,
    input  logic [sacr_pkg::TAG_W-1:0] i_tag,
    input  sacr_pkg::t_action          i_action,
    input  logic                       i_ignore_locked,
    input  logic                       i_new_valid,
    input  logic                       i_new_locked,
    input  logic                       i_mode,
    output sacr_pkg::t_result          o_res,
    output sacr_pkg::t_row             o_row,
    output logic                       o_we
);
    import sacr_pkg::*;

    logic [WAY_W-1:0] hs, first, next, pick, w, pw;
    logic             have_hit, have_first, have_next, take;
    logic [SET_W-1:0] set_idx;

    assign set_idx = i_tag[SET_W-1:0];

    always_comb begin
        hs = '0; have_hit = 1'b0;
        first = '0; next = '0; have_first = 1'b0; have_next = 1'b0;
        pick = '0; take = 1'b0; w = '0; pw = '0;
        o_res = '0;
        o_row = i_row;
        o_we  = 1'b0;

        for (int s = 0; s < WAYS; s++) begin
            w = i_row.order[s];
            if (!have_hit && i_row.valid[w] && i_row.tag[w] == i_tag) begin
                have_hit = 1'b1;
                hs = WAY_W'(s);
            end
        end

        // scan oldest to newest
        for (int s = WAYS - 1; s >= 0; s--) begin
            w = i_row.order[s];
            if (!i_row.valid[w]) begin
                first = WAY_W'(s); have_first = 1'b1;
                next  = WAY_W'(s); have_next  = 1'b1;
            end else if (!have_first && !i_row.locked[w]) begin
                first = WAY_W'(s); have_first = 1'b1;
            end else if (!have_next && !i_row.locked[w]) begin
                next = WAY_W'(s); have_next = 1'b1;
            end
        end
        if (i_mode && have_next) begin
            first = next; have_first = 1'b1;
        end
        if (have_first) begin
            pick = first; take = 1'b1;
        end else if (i_ignore_locked) begin
            pick = WAY_W'(WAYS - 1); take = 1'b1;
        end

        if (have_hit && (i_action == ACT_LOOKUP || i_action == ACT_REPLACE
                         || i_action == ACT_FLAGS)) begin
            pw = i_row.order[hs];
            o_res.hit     = 1'b1;
            o_res.found   = 1'b1;
            o_res.line_id = ID_W'({set_idx, pw});
            if (i_action == ACT_LOOKUP) begin
                o_row.order = to_front(i_row.order, hs);
                o_we = 1'b1;
            end else if (i_action == ACT_FLAGS) begin
                o_row.valid[pw]  = i_new_valid;
                o_row.locked[pw] = i_new_locked;
                o_we = 1'b1;
            end
        end else if (i_action == ACT_REPLACE && take) begin
            pw = i_row.order[pick];
            o_res.found   = 1'b1;
            o_res.line_id = ID_W'({set_idx, pw});
            if (i_row.valid[pw]) begin
                o_res.victim_valid        = 1'b1;
                o_res.victim_line_address = 27'(i_row.tag[pw]);
            end
            o_row.tag[pw]    = i_tag;
            o_row.valid[pw]  = 1'b1;
            o_row.locked[pw] = i_new_locked;
            o_row.order      = to_front(i_row.order, pick);
            o_we = 1'b1;
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cache tag and LRU replacement engine against a behavioral
// predictor: directed corner items, then random traffic over a few hot sets
// in both victim modes, with random start gaps on the command side.
// ----------------------------------------------------------------------------
module testbench;
    import sacr_pkg::*;

    typedef struct {
        t_action     action;
        logic [31:0] address;
        logic        ign;
        logic        nv;
        logic        nl;
    } t_cmd;

    localparam t_action ACT_UNUSED = 2'd3;
    localparam int      IDLE_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [31:0] i_address;
    logic        i_ignore_locked;
    logic        i_new_valid;
    logic        i_new_locked;
    logic        o_valid;
    logic        o_hit;
    logic        o_found;
    logic [9:0]  o_line_id;
    logic        o_victim_valid;
    logic [26:0] o_victim_line_address;

    set_assoc_cache_replacement_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .start                 (start),
        .busy                  (busy),
        .i_action              (i_action),
        .i_address             (i_address),
        .i_ignore_locked       (i_ignore_locked),
        .i_new_valid           (i_new_valid),
        .i_new_locked          (i_new_locked),
        .o_valid               (o_valid),
        .o_hit                 (o_hit),
        .o_found               (o_found),
        .o_line_id             (o_line_id),
        .o_victim_valid        (o_victim_valid),
        .o_victim_line_address (o_victim_line_address)
    );

    // shadow cache state
    logic [TAG_W-1:0]  shadow_tag    [NUM_SETS*WAYS];
    logic              shadow_valid  [NUM_SETS*WAYS];
    logic              shadow_locked [NUM_SETS*WAYS];
    logic [WAY_W-1:0]  shadow_order  [NUM_SETS][WAYS];
    logic              shadow_nxlru;

    t_cmd    pending_cmds[$];
    t_result expected_results[$];
    int      issued_cnt;
    int      accepted_cnt;
    int      gap_left;
    bit      no_gaps;
    bit      failed;
    int      idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void move_to_front(input int set_idx, input int slot);
        logic [WAY_W-1:0] w;
        w = shadow_order[set_idx][slot];
        for (int s = slot; s > 0; s--) shadow_order[set_idx][s] = shadow_order[set_idx][s-1];
        shadow_order[set_idx][0] = w;
    endfunction

    function automatic t_result predict_access(input t_cmd c);
        t_result          r;
        logic [TAG_W-1:0] tag;
        int               set_idx, base, hit_slot, id, pick, first, nxt, lid;
        bit               have_first, have_next, chosen;
        r        = '0;
        tag      = c.address[31:OFF_W];
        set_idx  = c.address[OFF_W +: SET_W];
        base     = set_idx * WAYS;
        hit_slot = WAYS;
        if (c.action == ACT_UNUSED) return r;
        for (int s = WAYS - 1; s >= 0; s--) begin
            id = base + shadow_order[set_idx][s];
            if (shadow_valid[id] && shadow_tag[id] == tag) hit_slot = s;
        end
        if (hit_slot < WAYS) begin
            id = base + shadow_order[set_idx][hit_slot];
            if (c.action == ACT_LOOKUP) begin
                move_to_front(set_idx, hit_slot);
            end else if (c.action == ACT_FLAGS) begin
                shadow_valid[id]  = c.nv;
                shadow_locked[id] = c.nl;
            end
            r.hit     = 1'b1;
            r.found   = 1'b1;
            r.line_id = ID_W'(id);
            return r;
        end
        if (c.action != ACT_REPLACE) return r;
        have_first = 0;
        have_next  = 0;
        first      = 0;
        nxt        = 0;
        // oldest to newest; an invalid way overrides both picks
        for (int s = WAYS - 1; s >= 0; s--) begin
            lid = base + shadow_order[set_idx][s];
            if (!shadow_valid[lid]) begin
                first = s; have_first = 1;
                nxt   = s; have_next  = 1;
            end else if (!have_first && !shadow_locked[lid]) begin
                first = s; have_first = 1;
            end else if (!have_next && !shadow_locked[lid]) begin
                nxt = s; have_next = 1;
            end
        end
        if (shadow_nxlru && have_next) begin
            first      = nxt;
            have_first = 1;
        end
        chosen = 1;
        if (have_first) pick = first;
        else if (c.ign) pick = WAYS - 1;
        else chosen = 0;
        if (!chosen) return r;
        id        = base + shadow_order[set_idx][pick];
        r.found   = 1'b1;
        r.line_id = ID_W'(id);
        if (shadow_valid[id]) begin
            r.victim_valid        = 1'b1;
            r.victim_line_address = 27'(shadow_tag[id]);
        end
        shadow_tag[id]    = tag;
        shadow_valid[id]  = 1'b1;
        shadow_locked[id] = c.nl;
        move_to_front(set_idx, pick);
        return r;
    endfunction

    function automatic t_cmd make_cmd(input t_action a, input logic [31:0] addr,
                                      input logic ign, input logic nv, input logic nl);
        t_cmd c;
        c.action  = a;
        c.address = addr;
        c.ign     = ign;
        c.nv      = nv;
        c.nl      = nl;
        return c;
    endfunction

    // hot sets and a handful of tags each, so sets overflow and hits are common
    function automatic t_cmd random_cmd();
        t_cmd        c;
        logic [18:0] hi;
        logic [7:0]  set_sel;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 30) c.action = ACT_LOOKUP;
        else if (r < 72) c.action = ACT_REPLACE;
        else if (r < 95) c.action = ACT_FLAGS;
        else c.action = ACT_UNUSED;
        case ($urandom_range(0, 5))
            0:       hi = 19'h7FFFF;
            1:       hi = 19'($urandom);
            default: hi = 19'($urandom_range(0, 4));
        endcase
        case ($urandom_range(0, 4))
            0:       set_sel = 8'hFF;
            1:       set_sel = 8'($urandom);
            default: set_sel = 8'($urandom_range(0, 2));
        endcase
        c.address = {hi, set_sel, 5'($urandom)};
        if ($urandom_range(0, 19) == 0) c.address = $urandom;
        c.ign = $urandom_range(0, 1);
        c.nv  = ($urandom_range(0, 3) != 0);
        c.nl  = ($urandom_range(0, 2) == 0);
        return c;
    endfunction

    // driver: one item per start; gap drawn per item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!(start && accepted_cnt != issued_cnt)) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
                t_cmd c;
                c = pending_cmds.pop_front();
                i_action        <= c.action;
                i_address       <= c.address;
                i_ignore_locked <= c.ign;
                i_new_valid     <= c.nv;
                i_new_locked    <= c.nl;
                start           <= 1'b1;
                issued_cnt      <= issued_cnt + 1;
                gap_left        <= no_gaps ? 0 : $urandom_range(0, 18);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check the result first, then predict the item taken this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                t_result got, want;
                got = '{o_hit, o_found, o_line_id, o_victim_valid, o_victim_line_address};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    failed = 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit)
                        $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
                    if (got.found !== want.found)
                        $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
                    if (got.line_id !== want.line_id)
                        $display("%0t: line_id exp %0d got %0d", $time,
                                 want.line_id, got.line_id);
                    if (got.victim_valid !== want.victim_valid)
                        $display("%0t: victim_valid exp %0d got %0d", $time,
                                 want.victim_valid, got.victim_valid);
                    if (got.victim_line_address !== want.victim_line_address)
                        $display("%0t: victim_line_address exp %h got %h", $time,
                                 want.victim_line_address, got.victim_line_address);
                    if (got !== want) failed = 1;
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_access(
                    make_cmd(i_action, i_address, i_ignore_locked, i_new_valid, i_new_locked)));
                accepted_cnt <= accepted_cnt + 1;
            end
            idle_cycles <= ((start && !busy) || o_valid) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_cmds.size() > 0 || issued_cnt != accepted_cnt
               || expected_results.size() > 0 || start)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_nxlru = mode;
    endtask

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pending_cmds.push_back(random_cmd());
        end
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        start           = 1'b0;
        i_action        = ACT_LOOKUP;
        i_address       = '0;
        i_ignore_locked = 1'b0;
        i_new_valid     = 1'b0;
        i_new_locked    = 1'b0;
        issued_cnt      = 0;
        accepted_cnt    = 0;
        gap_left        = 0;
        no_gaps         = 0;
        failed          = 0;
        idle_cycles     = 0;
        shadow_nxlru    = 1'b0;
        for (int i = 0; i < NUM_SETS * WAYS; i++) begin
            shadow_tag[i]    = '0;
            shadow_valid[i]  = 1'b0;
            shadow_locked[i] = 1'b0;
        end
        for (int s = 0; s < NUM_SETS; s++)
            for (int k = 0; k < WAYS; k++) shadow_order[s][k] = WAY_W'(k);
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-set miss, fill with locked lines, all-locked cases
        pending_cmds.push_back(make_cmd(ACT_LOOKUP,  32'h0000_0000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, 32'h0000_0000, 0, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_LOOKUP,  32'h0000_001F, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, 32'hFFFF_FFFF, 0, 1, 1));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, 32'hFFFF_FFFF, 1, 1, 0));
        for (int k = 0; k < 4; k++)
            pending_cmds.push_back(make_cmd(ACT_REPLACE, {19'(k + 1), 8'd7, 5'd3}, 0, 1, 1));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, {19'd9, 8'd7, 5'd0}, 0, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, {19'd9, 8'd7, 5'd0}, 1, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_LOOKUP,  {19'd2, 8'd7, 5'd0}, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_FLAGS,   {19'd3, 8'd7, 5'd0}, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_FLAGS,   {19'd4, 8'd7, 5'd0}, 0, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_FLAGS,   {19'd5, 8'd7, 5'd0}, 0, 1, 1));
        pending_cmds.push_back(make_cmd(ACT_LOOKUP,  {19'd3, 8'd7, 5'd0}, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, {19'd11, 8'd7, 5'd0}, 0, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, {19'd12, 8'd7, 5'd0}, 0, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_UNUSED,  32'hFFFF_FFFF, 1, 1, 1));
        pending_cmds.push_back(make_cmd(ACT_UNUSED,  32'h0000_0000, 0, 0, 0));
        drain();

        // nxlru mode on a set with mixed locked lines
        write_mode(1'b1);
        pending_cmds.push_back(make_cmd(ACT_FLAGS,   {19'd4, 8'd7, 5'd0}, 0, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, {19'd13, 8'd7, 5'd0}, 0, 1, 0));
        pending_cmds.push_back(make_cmd(ACT_REPLACE, {19'd14, 8'd7, 5'd0}, 0, 1, 0));
        drain();
        random_phase(250);
        write_mode(1'b0);
        random_phase(250);
        write_mode(1'b1);
        random_phase(200);
        write_mode(1'b0);
        random_phase(180);

        repeat (10) @(posedge i_clk);
        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### set_assoc_cache_replacement_core.f
hw/rtl/sacr_pkg.sv
hw/rtl/sacr_set_ram.sv
hw/rtl/sacr_pick.sv
hw/rtl/set_assoc_cache_replacement_core.sv
test/testbench.sv
